### rtl/core/cos_pkg.sv
package cos_pkg;

  // Event codes carried by the operation field.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_POINT = 2'd2;
  localparam logic [1:0] OP_DROP  = 2'd3;

  // Kinds of request that a result reports.
  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_ADDR = 2'd1;
  localparam logic [1:0] SEND_TIME = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKER_IP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKER_PORT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;

  localparam logic [31:0] INTERVAL_RST = 32'd60000000;
  localparam logic [31:0] TIMEOUT_RST  = 32'd180000000;
  localparam logic [31:0] LOOPBACK_IP  = 32'h7F00_0001;

  // Reciprocal of three for exact 32-bit quotients: q = (x * RECIP3) >> 33.
  localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
  localparam logic [31:0] THIRD_2P32 = 32'h5555_5555;

  typedef struct packed {
    logic [1:0]  operation;
    logic [62:0] now_us;
    logic [62:0] remote_us;
    logic [15:0] cluster_id;
    logic [31:0] point_ip;
    logic [15:0] point_port;
  } in_t;

  typedef struct packed {
    logic [1:0]         send_kind;
    logic [31:0]        dest_ip;
    logic [15:0]        dest_port;
    logic signed [63:0] offset_us;
    logic signed [63:0] trip_us;
  } out_t;

  typedef struct packed {
    logic [31:0] tracker_ip;
    logic [15:0] tracker_port;
    logic [15:0] server_cluster_id;
    logic [31:0] sync_interval_us;
    logic [31:0] sync_timeout_us;
  } cfg_t;

  // Pipeline advance enables: adv moves the back stages, adv_front the front.
  typedef struct packed {
    logic adv;
    logic adv_front;
  } pipe_ctl_t;

  // Per-item fields that ride along to the result.
  typedef struct packed {
    logic               reply;
    logic [1:0]         kind;
    logic [31:0]        dip;
    logic [15:0]        dport;
    logic signed [63:0] trip;
  } meta_t;

  // Record handed from the event stage to the estimator.
  typedef struct packed {
    meta_t              meta;
    logic signed [63:0] rel;
  } rec_t;

endpackage

### rtl/core/clock_offset_sync_client.sv
// Clock offset sync client: every event (tick, time reply, server point
// message, server drop) carries the local microsecond time and yields exactly
// one result, which names the request to send, if any, the smoothed
// remote-minus-local offset after the event and the round trip of a time
// reply. Results pass the input register, stages two to four and the output
// register; one event per cycle is taken unless the output is held, except for
// two time replies in adjacent slots: the estimate update loop (distance to the
// raw offset, then one third of it added back) spans two stages, so the second
// reply waits in stage two behind the first. Configuration writes are taken at
// any time and should only be made while no event is in flight.
module clock_offset_sync_client (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  cos_pkg::in_t                  in_data,

  output logic                          out_valid,
  input  logic                          out_ready,
  output cos_pkg::out_t                 out_data,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  cos_pkg::cfg_t      cfg;
  cos_pkg::pipe_ctl_t pc;
  cos_pkg::rec_t      rec;
  cos_pkg::out_t      res;
  logic               rec_valid;
  logic               res_valid;
  logic               hazard;
  logic               out_valid_r;
  cos_pkg::out_t      out_data_r;

  // The back stages move while the output register is free or being emptied.
  assign pc.adv       = !out_valid_r || out_ready;
  assign pc.adv_front = pc.adv && !hazard;
  assign in_ready     = pc.adv_front;
  assign cfg_ready    = 1'b1;

  cos_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cos_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .pc        (pc),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  cos_est u_est (
    .clk       (clk),
    .rst_n     (rst_n),
    .pc        (pc),
    .rec_valid (rec_valid),
    .rec       (rec),
    .hazard    (hazard),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register; a result waits here until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pc.adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pc.adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/cos_cfg.sv
module cos_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [cos_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [31:0]                      wr_data,
  output cos_pkg::cfg_t                    cfg
);

  cos_pkg::cfg_t cfg_r;
  cos_pkg::cfg_t cfg_nxt;

  // Decode the register index; indexes past the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        cos_pkg::CFG_TRACKER_IP:   cfg_nxt.tracker_ip        = wr_data;
        cos_pkg::CFG_TRACKER_PORT: cfg_nxt.tracker_port      = wr_data[15:0];
        cos_pkg::CFG_SERVER_ID:    cfg_nxt.server_cluster_id = wr_data[15:0];
        cos_pkg::CFG_INTERVAL:     cfg_nxt.sync_interval_us  = wr_data;
        cos_pkg::CFG_TIMEOUT:      cfg_nxt.sync_timeout_us   = wr_data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tracker_ip        <= '0;
      cfg_r.tracker_port      <= '0;
      cfg_r.server_cluster_id <= '0;
      cfg_r.sync_interval_us  <= cos_pkg::INTERVAL_RST;
      cfg_r.sync_timeout_us   <= cos_pkg::TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/cos_ctl.sv
module cos_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  cos_pkg::pipe_ctl_t pc,
  input  cos_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  cos_pkg::in_t       in_data,
  output logic               rec_valid,
  output cos_pkg::rec_t      rec
);

  // Input register.
  logic         s1_v_r;
  cos_pkg::in_t in_r;

  // Event state.
  logic [62:0] last_req_r, last_req_nxt;
  logic [62:0] last_rep_r, last_rep_nxt;
  logic        first_r, first_nxt;
  logic [31:0] srv_ip_r, srv_ip_nxt;
  logic [15:0] srv_port_r, srv_port_nxt;

  logic        fire;
  logic [63:0] d_rep;
  logic [63:0] d_req;
  logic        timed_out;
  logic        interval_up;
  logic [63:0] trip;
  logic [63:0] rel;

  assign fire = pc.adv_front && s1_v_r;

  // Elapsed time checks; time running backwards never counts as elapsed.
  assign d_rep       = {1'b0, in_r.now_us} - {1'b0, last_rep_r};
  assign d_req       = {1'b0, in_r.now_us} - {1'b0, last_req_r};
  assign timed_out   = !d_rep[63] && (d_rep[62:0] > {31'b0, cfg.sync_timeout_us});
  assign interval_up = !d_req[63] && (d_req[62:0] > {31'b0, cfg.sync_interval_us});

  // Both operands are below 2^63, so the signed differences fit in 64 bits.
  assign trip = d_req;
  assign rel  = {1'b0, in_r.remote_us} - {1'b0, last_req_r};

  // Event decode and state update.
  always_comb begin
    last_req_nxt   = last_req_r;
    last_rep_nxt   = last_rep_r;
    first_nxt      = first_r;
    srv_ip_nxt     = srv_ip_r;
    srv_port_nxt   = srv_port_r;
    rec.meta.reply = 1'b0;
    rec.meta.kind  = cos_pkg::SEND_NONE;
    rec.meta.dip   = '0;
    rec.meta.dport = '0;
    rec.meta.trip  = '0;
    rec.rel        = rel;
    case (in_r.operation)
      cos_pkg::OP_TICK: begin
        if (first_r || timed_out) begin
          rec.meta.kind  = cos_pkg::SEND_ADDR;
          rec.meta.dip   = cfg.tracker_ip;
          rec.meta.dport = cfg.tracker_port;
          last_rep_nxt   = in_r.now_us;
          first_nxt      = 1'b0;
        end else if ((srv_port_r != '0) && interval_up) begin
          rec.meta.kind  = cos_pkg::SEND_TIME;
          rec.meta.dip   = srv_ip_r;
          rec.meta.dport = srv_port_r;
          last_req_nxt   = in_r.now_us;
        end
      end
      cos_pkg::OP_REPLY: begin
        rec.meta.reply = 1'b1;
        rec.meta.trip  = trip;
        last_rep_nxt   = in_r.now_us;
        first_nxt      = 1'b0;
      end
      cos_pkg::OP_POINT: begin
        if (in_r.cluster_id == cfg.server_cluster_id) begin
          srv_ip_nxt   = (in_r.point_ip == cos_pkg::LOOPBACK_IP) ? cfg.tracker_ip
                                                                 : in_r.point_ip;
          srv_port_nxt = in_r.point_port;
        end
      end
      cos_pkg::OP_DROP: begin
        srv_ip_nxt   = '0;
        srv_port_nxt = '0;
      end
      default: begin
        srv_ip_nxt   = srv_ip_r;
      end
    endcase
  end

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pc.adv_front) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pc.adv_front) begin
      in_r <= in_data;
    end
  end

  // State commits when the item leaves this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_req_r <= '0;
      last_rep_r <= '0;
      first_r    <= 1'b1;
      srv_ip_r   <= '0;
      srv_port_r <= '0;
    end else if (fire) begin
      last_req_r <= last_req_nxt;
      last_rep_r <= last_rep_nxt;
      first_r    <= first_nxt;
      srv_ip_r   <= srv_ip_nxt;
      srv_port_r <= srv_port_nxt;
    end
  end

  assign rec_valid = s1_v_r;

endmodule

### rtl/core/cos_est.sv
module cos_est (
  input  logic               clk,
  input  logic               rst_n,
  input  cos_pkg::pipe_ctl_t pc,
  input  logic               rec_valid,
  input  cos_pkg::rec_t      rec,
  output logic               hazard,
  output logic               res_valid,
  output cos_pkg::out_t      res
);

  // Exact 32-bit divide by three: quotient in [32:2], remainder in [1:0].
  function automatic logic [32:0] div3_32(input logic [31:0] x);
    logic [63:0] p;
    logic [30:0] q;
    logic [1:0]  q3;
    p  = 64'(x) * 64'(cos_pkg::RECIP3);
    q  = p[63:33];
    q3 = q[1:0] + {q[0], 1'b0};
    return {q, x[1:0] - q3};
  endfunction

  // Stage 2: raw offset.
  logic               s2_v_r;
  cos_pkg::rec_t      s2_r;
  logic signed [63:0] half_fl;
  logic               half_fix;
  logic [64:0]        diff_sum;
  logic signed [63:0] diff;

  // Stage 3: distance to the estimate.
  logic               s3_v_r;
  cos_pkg::meta_t     s3_meta_r;
  logic signed [63:0] s3_diff_r;
  logic [64:0]        dlt;
  logic [63:0]        rev;
  logic [63:0]        mag;

  // Stage 4: one third of the distance, estimate update.
  logic               s4_v_r;
  cos_pkg::meta_t     s4_meta_r;
  logic [63:0]        s4_mag_r;
  logic               s4_neg_r;
  logic [32:0]        dh;
  logic [32:0]        dl;
  logic [63:0]        rmul;
  logic               rcarry;
  logic [63:0]        third;
  logic [63:0]        off_r, off_nxt;

  // trip/2 truncating toward zero is the floor shift plus one for odd negatives.
  assign half_fl  = s2_r.meta.trip >>> 1;
  assign half_fix = s2_r.meta.trip[63] & s2_r.meta.trip[0];
  assign diff_sum = {s2_r.rel[63], s2_r.rel} + {~half_fl[63], ~half_fl}
                  + {64'b0, ~half_fix};

  // Saturate the raw offset to the signed 64-bit range.
  always_comb begin
    if (diff_sum[64] != diff_sum[63]) begin
      diff = diff_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      diff = diff_sum[63:0];
    end
  end

  // Magnitude and direction of the step toward the raw offset.
  assign dlt = {s3_diff_r[63], s3_diff_r} - {off_r[63], off_r};
  assign rev = off_r - s3_diff_r;
  assign mag = dlt[64] ? rev : dlt[63:0];

  // mag/3 from the two 32-bit halves, using 2^32 = 3 * 0x55555555 + 1.
  assign dh     = div3_32(s4_mag_r[63:32]);
  assign dl     = div3_32(s4_mag_r[31:0]);
  assign rcarry = ({1'b0, dh[1:0]} + {1'b0, dl[1:0]}) >= 3'd3;

  always_comb begin
    case (dh[1:0])
      2'd1:    rmul = {32'b0, cos_pkg::THIRD_2P32};
      2'd2:    rmul = {31'b0, cos_pkg::THIRD_2P32, 1'b0};
      default: rmul = '0;
    endcase
  end

  assign third   = {1'b0, dh[32:2], 32'b0} + rmul + {33'b0, dl[32:2]} + {63'b0, rcarry};
  assign off_nxt = s4_neg_r ? (off_r - third) : (off_r + third);

  // A reply may not read the estimate while the previous reply is updating it.
  assign hazard = s2_v_r && s2_r.meta.reply && s3_v_r && s3_meta_r.reply;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (pc.adv_front) begin
        s2_v_r <= rec_valid;
      end
      if (pc.adv) begin
        s3_v_r <= s2_v_r && !hazard;
        s4_v_r <= s3_v_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (pc.adv_front) begin
      s2_r <= rec;
    end
    if (pc.adv) begin
      s3_meta_r <= s2_r.meta;
      s3_diff_r <= diff;
      s4_meta_r <= s3_meta_r;
      s4_mag_r  <= mag;
      s4_neg_r  <= dlt[64];
    end
  end

  // Offset estimate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (pc.adv && s4_v_r && s4_meta_r.reply) begin
      off_r <= off_nxt;
    end
  end

  // Result of the item in the last stage.
  always_comb begin
    res.send_kind = s4_meta_r.kind;
    res.dest_ip   = s4_meta_r.dip;
    res.dest_port = s4_meta_r.dport;
    res.offset_us = s4_meta_r.reply ? off_nxt : off_r;
    res.trip_us   = s4_meta_r.trip;
  end

  assign res_valid = s4_v_r;

endmodule
